>>> src/mcmd_pkg.sv
// Package for the MIDI channel message decoder: types, constants and the hertz table.
`default_nettype none
package mcmd_pkg;

   localparam int unsigned SYSEX_MAX_BYTES = 16;
   localparam int unsigned HDR_LEN = 5;
   localparam logic [4:0] COUNT_SAT = 5'd31;

   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned RSP_USER_W = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 7;

   localparam logic [7:0] ST_SYSEX_START = 8'hF0;
   localparam logic [7:0] ST_SYSEX_END = 8'hF7;
   localparam logic [7:0] ST_REALTIME = 8'hF8;
   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON = 4'h9;
   localparam logic [3:0] KIND_CTRL = 4'hB;
   localparam logic [3:0] KIND_PROGRAM = 4'hC;
   localparam logic [3:0] KIND_PRESSURE = 4'hD;

   typedef enum logic [1:0] {
      CSR_DEVICE_ID = 2'd0,
      CSR_MAKER_ID = 2'd1,
      CSR_GROUP_ID = 2'd2,
      CSR_CHANNEL_CMD = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NOTE_ON = 2'd0,
      EV_NOTE_RELEASE = 2'd1,
      EV_CTRL_CHANGE = 2'd2,
      EV_CHANNEL_SET = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [3:0] new_channel;
      logic [6:0] ctrl_value;
      logic [6:0] ctrl_number;
      logic [13:0] frequency_hz;
      logic [6:0] velocity;
      logic [6:0] note_number;
      event_kind_type event_kind;
   } result_type;

   localparam logic [13:0] HZ_ROM [128] = '{
      14'd8, 14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12,
      14'd12, 14'd13, 14'd14, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19,
      14'd20, 14'd21, 14'd23, 14'd24, 14'd25, 14'd27, 14'd29, 14'd30,
      14'd32, 14'd34, 14'd36, 14'd38, 14'd41, 14'd43, 14'd46, 14'd48,
      14'd51, 14'd54, 14'd58, 14'd61, 14'd65, 14'd69, 14'd73, 14'd77,
      14'd82, 14'd87, 14'd92, 14'd97, 14'd103, 14'd109, 14'd116, 14'd123,
      14'd130, 14'd138, 14'd146, 14'd155, 14'd164, 14'd174, 14'd184, 14'd195,
      14'd207, 14'd219, 14'd233, 14'd246, 14'd261, 14'd277, 14'd293, 14'd311,
      14'd329, 14'd349, 14'd369, 14'd391, 14'd415, 14'd440, 14'd466, 14'd493,
      14'd523, 14'd554, 14'd587, 14'd622, 14'd659, 14'd698, 14'd739, 14'd783,
      14'd830, 14'd880, 14'd932, 14'd987, 14'd1046, 14'd1108, 14'd1174, 14'd1244,
      14'd1318, 14'd1396, 14'd1479, 14'd1567, 14'd1661, 14'd1760, 14'd1864, 14'd1975,
      14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2793, 14'd2959, 14'd3135,
      14'd3322, 14'd3520, 14'd3729, 14'd3951, 14'd4186, 14'd4434, 14'd4698, 14'd4978,
      14'd5274, 14'd5587, 14'd5919, 14'd6271, 14'd6644, 14'd7040, 14'd7458, 14'd7902,
      14'd8372, 14'd8869, 14'd9397, 14'd9956, 14'd10548, 14'd11175, 14'd11839, 14'd12543
   };

endpackage
`default_nettype wire

>>> src/mcmd_in_stage.sv
// Input register for received bytes.
`default_nettype none
module mcmd_in_stage (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [mcmd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              take,
   output logic                                   byte_valid,
   output logic [7:0]                             byte_data
);
   import mcmd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in = (req_tvalid && req_tready) ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= req_tdata;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data = data_ff;
endmodule
`default_nettype wire

>>> src/mcmd_core.sv
// Decoder state, configuration registers and per-byte decode logic.
`default_nettype none
module mcmd_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [mcmd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mcmd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                               take,
   input  wire logic [7:0]                         byte_data,
   output logic                                    res_valid,
   output mcmd_pkg::result_type                    res_data
);
   import mcmd_pkg::*;

   logic [6:0] device_id_ff, maker_id_ff, group_id_ff, channel_cmd_ff;

   logic [3:0] listen_ff, listen_in;
   logic       capture_ff, capture_in;
   logic       sysex_ff, sysex_in;
   logic [4:0] count_ff, count_in;
   logic [7:0] running_ff, running_in;
   logic [6:0] first_ff, first_in;
   logic [6:0] last_note_ff, last_note_in;
   logic [6:0] header_ff [HDR_LEN];

   logic       hdr_we;
   logic [8:0] total;
   logic       sysex_ok;
   logic [6:0] chan_val;
   logic [3:0] kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= 7'd0;
         maker_id_ff <= 7'd68;
         group_id_ff <= 7'd3;
         channel_cmd_ff <= 7'd0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEVICE_ID: device_id_ff <= csr_wdata;
            CSR_MAKER_ID: maker_id_ff <= csr_wdata;
            CSR_GROUP_ID: group_id_ff <= csr_wdata;
            CSR_CHANNEL_CMD: channel_cmd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign kind = running_ff[7:4];
   assign total = {4'd0, count_ff} + 9'd2;
   assign chan_val = header_ff[4];
   assign sysex_ok = (count_ff >= 5'(HDR_LEN)) && (count_ff < COUNT_SAT) &&
                     (total < 9'(SYSEX_MAX_BYTES)) &&
                     (header_ff[0] == maker_id_ff) && (header_ff[1] == group_id_ff) &&
                     (header_ff[2] == device_id_ff) && (header_ff[3] == channel_cmd_ff) &&
                     (chan_val >= 7'd1) && (chan_val <= 7'd16);

   always_comb begin
      listen_in = listen_ff;
      capture_in = capture_ff;
      sysex_in = sysex_ff;
      count_in = count_ff;
      running_in = running_ff;
      first_in = first_ff;
      last_note_in = last_note_ff;
      hdr_we = 1'b0;
      res_valid = 1'b0;
      res_data = '0;
      if (byte_data >= ST_REALTIME) begin
         // real-time bytes leave everything alone
      end else if (byte_data[7]) begin
         if (byte_data == ST_SYSEX_END && sysex_ff) begin
            sysex_in = 1'b0;
            if (sysex_ok) begin
               listen_in = 4'(chan_val - 7'd1);
               res_valid = 1'b1;
               res_data.event_kind = EV_CHANNEL_SET;
               res_data.new_channel = 4'(chan_val - 7'd1);
            end
         end else begin
            sysex_in = 1'b0;
            if (byte_data == ST_SYSEX_START) begin
               sysex_in = 1'b1;
               capture_in = 1'b0;
               count_in = 5'd0;
            end else if (byte_data < ST_SYSEX_START && byte_data[3:0] == listen_ff) begin
               capture_in = 1'b1;
               running_in = byte_data;
               count_in = 5'd0;
            end else begin
               capture_in = 1'b0;
            end
         end
      end else if (sysex_ff) begin
         hdr_we = count_ff < 5'(HDR_LEN);
         if (count_ff < COUNT_SAT) begin
            count_in = count_ff + 5'd1;
         end
      end else if (capture_ff) begin
         if (kind == KIND_PROGRAM || kind == KIND_PRESSURE) begin
            count_in = 5'd0;
         end else if (count_ff == 5'd0) begin
            first_in = byte_data[6:0];
            count_in = 5'd1;
         end else begin
            count_in = 5'd0;
            case (kind)
               KIND_NOTE_ON: begin
                  last_note_in = first_ff;
                  res_valid = 1'b1;
                  res_data.event_kind = EV_NOTE_ON;
                  res_data.note_number = first_ff;
                  res_data.velocity = byte_data[6:0];
                  res_data.frequency_hz = HZ_ROM[first_ff];
               end
               KIND_NOTE_OFF: begin
                  if (first_ff == last_note_ff) begin
                     res_valid = 1'b1;
                     res_data.event_kind = EV_NOTE_RELEASE;
                     res_data.note_number = first_ff;
                  end
               end
               KIND_CTRL: begin
                  res_valid = 1'b1;
                  res_data.event_kind = EV_CTRL_CHANGE;
                  res_data.ctrl_number = first_ff;
                  res_data.ctrl_value = byte_data[6:0];
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff <= 4'd0;
         capture_ff <= 1'b0;
         sysex_ff <= 1'b0;
         count_ff <= 5'd0;
         running_ff <= 8'd0;
         first_ff <= 7'd0;
         last_note_ff <= 7'd0;
      end else if (take) begin
         listen_ff <= listen_in;
         capture_ff <= capture_in;
         sysex_ff <= sysex_in;
         count_ff <= count_in;
         running_ff <= running_in;
         first_ff <= first_in;
         last_note_ff <= last_note_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && hdr_we) begin
         header_ff[count_ff[2:0]] <= byte_data[6:0];
      end
   end
endmodule
`default_nettype wire

>>> src/mcmd_out_stage.sv
// Result register and stall control towards the result channel.
`default_nettype none
module mcmd_out_stage (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              byte_valid,
   output logic                                   take,
   input  wire logic                              res_valid,
   input  wire mcmd_pkg::result_type              res_data,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [mcmd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [mcmd_pkg::RSP_USER_W-1:0]        rsp_tuser
);
   import mcmd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign take = byte_valid && (!valid_ff || rsp_tready);
   assign valid_in = take ? res_valid : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         data_ff <= res_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser = data_ff.event_kind;
   assign rsp_tdata = {2'b00, data_ff.new_channel, data_ff.ctrl_value, data_ff.ctrl_number,
                       data_ff.frequency_hz, data_ff.velocity, data_ff.note_number};
endmodule
`default_nettype wire

>>> src/midi_channel_message_decoder_unit.sv
// Top level of the MIDI channel message decoder.
// Usage:
//  req_* carries one received MIDI byte per transfer in req_tdata[7:0].
//  rsp_* carries at most one event per byte: event kind in rsp_tuser, the
//  event fields in rsp_tdata. Fields not used by an event read as zero.
//  csr_* writes device, maker, group and channel-command registers; the user
//  must write them only while no byte is in flight, which the block does not enforce.
// Order: rsp_tvalid rises once a req byte has passed the input register, the
//  decode step and the result register. Throughput: one byte per cycle while
//  results are taken, set by the single decode step between the two registers;
//  bytes that give no event pass through at the same rate.
// Reset (synchronous, high): listened channel 0, capture and exclusive
//  collection off, registers to their defaults, both stages empty.
// Stall: while rsp_tready is low with a result held, the decode stage stops;
//  at most one more byte is taken into the input register, then req_tready drops.
`default_nettype none
module midi_channel_message_decoder_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [7:0] rx_byte
   input  wire logic [mcmd_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [6:0] note_number, [13:7] velocity, [27:14] frequency_hz,
   // [34:28] ctrl_number, [41:35] ctrl_value, [45:42] new_channel
   output logic [mcmd_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // [1:0] event_kind
   output logic [mcmd_pkg::RSP_USER_W-1:0]         rsp_tuser,
   input  wire logic                               csr_we,
   input  wire logic [mcmd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mcmd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mcmd_pkg::*;

   logic       take;
   logic       byte_valid;
   logic [7:0] byte_data;
   logic       res_valid;
   result_type res_data;

   mcmd_in_stage u_in (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .take(take), .byte_valid(byte_valid), .byte_data(byte_data)
   );

   mcmd_core u_core (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .take(take), .byte_data(byte_data),
      .res_valid(res_valid), .res_data(res_data)
   );

   mcmd_out_stage u_out (
      .clock(clock), .reset(reset),
      .byte_valid(byte_valid), .take(take),
      .res_valid(res_valid), .res_data(res_data),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );
endmodule
`default_nettype wire

>>> tb/midi_event_checker.sv
// Checker for the MIDI channel message decoder: predicts events from accepted bytes and compares.
`timescale 1ns / 1ps
module midi_event_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   input  wire logic [mcmd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic [mcmd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic [mcmd_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  wire logic                                csr_we,
   input  wire logic [mcmd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mcmd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                       fail_count,
   output int                                       pending_count,
   output int                                       bytes_seen,
   output int                                       note_on_seen,
   output int                                       release_seen,
   output int                                       ctrl_seen,
   output int                                       chan_set_seen
);
   import mcmd_pkg::*;

   localparam logic [6:0] MAKER_AT_RESET = 7'd68;
   localparam logic [6:0] GROUP_AT_RESET = 7'd3;
   localparam int PRINT_LIMIT = 40;

   localparam logic [13:0] HERTZ_OF_NOTE [128] = '{
      14'd8, 14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12,
      14'd12, 14'd13, 14'd14, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19,
      14'd20, 14'd21, 14'd23, 14'd24, 14'd25, 14'd27, 14'd29, 14'd30,
      14'd32, 14'd34, 14'd36, 14'd38, 14'd41, 14'd43, 14'd46, 14'd48,
      14'd51, 14'd54, 14'd58, 14'd61, 14'd65, 14'd69, 14'd73, 14'd77,
      14'd82, 14'd87, 14'd92, 14'd97, 14'd103, 14'd109, 14'd116, 14'd123,
      14'd130, 14'd138, 14'd146, 14'd155, 14'd164, 14'd174, 14'd184, 14'd195,
      14'd207, 14'd219, 14'd233, 14'd246, 14'd261, 14'd277, 14'd293, 14'd311,
      14'd329, 14'd349, 14'd369, 14'd391, 14'd415, 14'd440, 14'd466, 14'd493,
      14'd523, 14'd554, 14'd587, 14'd622, 14'd659, 14'd698, 14'd739, 14'd783,
      14'd830, 14'd880, 14'd932, 14'd987, 14'd1046, 14'd1108, 14'd1174, 14'd1244,
      14'd1318, 14'd1396, 14'd1479, 14'd1567, 14'd1661, 14'd1760, 14'd1864, 14'd1975,
      14'd2093, 14'd2217, 14'd2349, 14'd2489, 14'd2637, 14'd2793, 14'd2959, 14'd3135,
      14'd3322, 14'd3520, 14'd3729, 14'd3951, 14'd4186, 14'd4434, 14'd4698, 14'd4978,
      14'd5274, 14'd5587, 14'd5919, 14'd6271, 14'd6644, 14'd7040, 14'd7458, 14'd7902,
      14'd8372, 14'd8869, 14'd9397, 14'd9956, 14'd10548, 14'd11175, 14'd11839, 14'd12543
   };

   logic [6:0] device_reg, maker_reg, group_reg, cmd_reg;
   logic [3:0] listen_chan;
   logic       capturing;
   logic       in_exclusive;
   logic [4:0] data_count;
   logic [7:0] run_status;
   logic [6:0] first_byte;
   logic [6:0] sx_head [HDR_LEN];
   logic [6:0] held_note;

   result_type pending_events [$];

   int failures = 0;
   int pending_depth = 0;
   int n_bytes = 0;
   int n_note_on = 0;
   int n_release = 0;
   int n_ctrl = 0;
   int n_chan_set = 0;

   assign fail_count = failures;
   assign pending_count = pending_depth;
   assign bytes_seen = n_bytes;
   assign note_on_seen = n_note_on;
   assign release_seen = n_release;
   assign ctrl_seen = n_ctrl;
   assign chan_set_seen = n_chan_set;

   task automatic flag_mismatch(input string what, input logic [15:0] got,
                                input logic [15:0] want);
      if (failures < PRINT_LIMIT)
         $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      failures++;
   endtask

   // One received byte through the decoder state; queues the event it causes.
   task automatic decode_midi_byte(input logic [7:0] b);
      result_type ev;
      logic       hit;
      logic [3:0] kind;
      logic [6:0] chan_value;
      ev = '0;
      hit = 1'b0;
      kind = run_status[7:4];
      if (b < ST_REALTIME) begin
         if (b[7]) begin
            if (b == ST_SYSEX_END && in_exclusive) begin
               in_exclusive = 1'b0;
               chan_value = sx_head[4];
               if (data_count >= HDR_LEN && data_count < COUNT_SAT
                   && int'(data_count) + 2 < SYSEX_MAX_BYTES
                   && sx_head[0] == maker_reg && sx_head[1] == group_reg
                   && sx_head[2] == device_reg && sx_head[3] == cmd_reg
                   && chan_value >= 7'd1 && chan_value <= 7'd16) begin
                  listen_chan = 4'(chan_value - 7'd1);
                  ev.event_kind = EV_CHANNEL_SET;
                  ev.new_channel = listen_chan;
                  hit = 1'b1;
               end
            end else begin
               in_exclusive = 1'b0;
               if (b == ST_SYSEX_START) begin
                  in_exclusive = 1'b1;
                  capturing = 1'b0;
                  data_count = '0;
               end else if (b < ST_SYSEX_START && b[3:0] == listen_chan) begin
                  capturing = 1'b1;
                  run_status = b;
                  data_count = '0;
               end else begin
                  capturing = 1'b0;
               end
            end
         end else if (in_exclusive) begin
            if (data_count < HDR_LEN)
               sx_head[data_count[2:0]] = b[6:0];
            if (data_count < COUNT_SAT)
               data_count = data_count + 5'd1;
         end else if (capturing) begin
            if (kind == KIND_PROGRAM || kind == KIND_PRESSURE) begin
               data_count = '0;
            end else if (data_count == '0) begin
               first_byte = b[6:0];
               data_count = 5'd1;
            end else begin
               data_count = '0;
               if (kind == KIND_NOTE_ON) begin
                  held_note = first_byte;
                  ev.event_kind = EV_NOTE_ON;
                  ev.note_number = first_byte;
                  ev.velocity = b[6:0];
                  ev.frequency_hz = HERTZ_OF_NOTE[first_byte];
                  hit = 1'b1;
               end else if (kind == KIND_NOTE_OFF) begin
                  if (first_byte == held_note) begin
                     ev.event_kind = EV_NOTE_RELEASE;
                     ev.note_number = first_byte;
                     hit = 1'b1;
                  end
               end else if (kind == KIND_CTRL) begin
                  ev.event_kind = EV_CTRL_CHANGE;
                  ev.ctrl_number = first_byte;
                  ev.ctrl_value = b[6:0];
                  hit = 1'b1;
               end
            end
         end
      end
      if (hit)
         pending_events.push_back(ev);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         device_reg = '0;
         maker_reg = MAKER_AT_RESET;
         group_reg = GROUP_AT_RESET;
         cmd_reg = '0;
         listen_chan = '0;
         capturing = 1'b0;
         in_exclusive = 1'b0;
         data_count = '0;
         run_status = '0;
         first_byte = '0;
         held_note = '0;
         pending_events.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEVICE_ID:   device_reg = csr_wdata;
               CSR_MAKER_ID:    maker_reg = csr_wdata;
               CSR_GROUP_ID:    group_reg = csr_wdata;
               CSR_CHANNEL_CMD: cmd_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               flag_mismatch("event with none pending, kind", 16'(rsp_tuser), 16'd0);
            end else begin
               want = pending_events.pop_front();
               if (rsp_tuser !== want.event_kind)
                  flag_mismatch("event_kind", 16'(rsp_tuser), 16'(want.event_kind));
               if (rsp_tdata[6:0] !== want.note_number)
                  flag_mismatch("note_number", 16'(rsp_tdata[6:0]), 16'(want.note_number));
               if (rsp_tdata[13:7] !== want.velocity)
                  flag_mismatch("velocity", 16'(rsp_tdata[13:7]), 16'(want.velocity));
               if (rsp_tdata[27:14] !== want.frequency_hz)
                  flag_mismatch("frequency_hz", 16'(rsp_tdata[27:14]),
                                16'(want.frequency_hz));
               if (rsp_tdata[34:28] !== want.ctrl_number)
                  flag_mismatch("ctrl_number", 16'(rsp_tdata[34:28]), 16'(want.ctrl_number));
               if (rsp_tdata[41:35] !== want.ctrl_value)
                  flag_mismatch("ctrl_value", 16'(rsp_tdata[41:35]), 16'(want.ctrl_value));
               if (rsp_tdata[45:42] !== want.new_channel)
                  flag_mismatch("new_channel", 16'(rsp_tdata[45:42]), 16'(want.new_channel));
               if (rsp_tdata[47:46] !== 2'b00)
                  flag_mismatch("tdata padding", 16'(rsp_tdata[47:46]), 16'd0);
               case (want.event_kind)
                  EV_NOTE_ON:      n_note_on++;
                  EV_NOTE_RELEASE: n_release++;
                  EV_CTRL_CHANGE:  n_ctrl++;
                  default:         n_chan_set++;
               endcase
            end
         end
         if (req_tvalid && req_tready) begin
            n_bytes++;
            decode_midi_byte(req_tdata);
         end
      end
      pending_depth <= pending_events.size();
   end

endmodule

>>> tb/midi_channel_message_decoder_unit_test.sv
// Testbench top for the MIDI channel message decoder: byte stimulus, pacing and verdict.
`timescale 1ns / 1ps
module midi_channel_message_decoder_unit_test;
   import mcmd_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 335;
   localparam int HOLD_CYCLES = 240;
   localparam int OPENING_LEN = 28;
   localparam logic [3:0] KIND_POLY_TOUCH = 4'hA;
   localparam logic [3:0] KIND_PITCH_WHEEL = 4'hE;

   // extremes, running status, release hit and miss, controller, program,
   // system common, stray data, channel set to 15, note on the new channel
   localparam logic [7:0] OPENING_BYTES [OPENING_LEN] = '{
      8'h90, 8'h00, 8'h7F, 8'h7F, 8'h00, 8'hF8, 8'h80, 8'h7F, 8'h00, 8'h05,
      8'h00, 8'hB0, 8'h7F, 8'h7F, 8'hC0, 8'h05, 8'hF1, 8'h33, 8'hF0, 8'h44,
      8'h03, 8'h00, 8'h00, 8'h10, 8'hF7, 8'h9F, 8'h3C, 8'h40
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count, pending_count, bytes_seen;
   int note_on_seen, release_seen, ctrl_seen, chan_set_seen;

   int cycle_count = 0;
   int send_idle_pct = 14;
   int take_idle_pct = 54;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int items_sent = 0;
   logic [3:0] cur_chan = 4'd0;
   logic [6:0] last_on_note = 7'd0;
   logic [6:0] device_reg = 7'd0;
   logic [6:0] maker_reg = 7'd68;
   logic [6:0] group_reg = 7'd3;
   logic [6:0] cmd_reg = 7'd0;

   midi_channel_message_decoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   midi_event_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .bytes_seen    (bytes_seen),
      .note_on_seen  (note_on_seen),
      .release_seen  (release_seen),
      .ctrl_seen     (ctrl_seen),
      .chan_set_seen (chan_set_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: random back-pressure, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   task automatic put_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (b < ST_REALTIME)
         items_sent++;
   endtask

   // real-time bytes may turn up between any two bytes of a message
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < 4)
         put_byte(8'($urandom_range(8'hF8, 8'hFF)));
      put_byte(b);
   endtask

   function automatic logic [6:0] data_value();
      case ($urandom_range(9))
         0: return 7'h00;
         1: return 7'h7F;
         default: return 7'($urandom_range(127));
      endcase
   endfunction

   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_registers(input logic [6:0] dev, input logic [6:0] maker,
                                input logic [6:0] group, input logic [6:0] cmd);
      csr_we <= 1'b1;
      csr_index <= CSR_DEVICE_ID;
      csr_wdata <= dev;
      @(posedge clock);
      csr_index <= CSR_MAKER_ID;
      csr_wdata <= maker;
      @(posedge clock);
      csr_index <= CSR_GROUP_ID;
      csr_wdata <= group;
      @(posedge clock);
      csr_index <= CSR_CHANNEL_CMD;
      csr_wdata <= cmd;
      @(posedge clock);
      csr_we <= 1'b0;
      device_reg = dev;
      maker_reg = maker;
      group_reg = group;
      cmd_reg = cmd;
   endtask

   // status byte then one to four data groups under running status
   task automatic send_voice_message();
      int pick;
      int groups;
      logic [3:0] kind;
      logic [3:0] chan;
      logic [6:0] d0;
      logic       pair;
      pick = $urandom_range(99);
      if (pick < 35) kind = KIND_NOTE_ON;
      else if (pick < 55) kind = KIND_NOTE_OFF;
      else if (pick < 75) kind = KIND_CTRL;
      else if (pick < 82) kind = KIND_PROGRAM;
      else if (pick < 88) kind = KIND_PRESSURE;
      else if (pick < 94) kind = KIND_POLY_TOUCH;
      else kind = KIND_PITCH_WHEEL;
      chan = ($urandom_range(9) < 8) ? cur_chan : 4'($urandom_range(15));
      pair = !(kind == KIND_PROGRAM || kind == KIND_PRESSURE);
      send_byte({kind, chan});
      groups = $urandom_range(1, 4);
      for (int g = 0; g < groups; g++) begin
         d0 = data_value();
         if (kind == KIND_NOTE_OFF && $urandom_range(99) < 70)
            d0 = last_on_note;
         send_byte({1'b0, d0});
         // a broken pair now and then: last group cut after its first byte
         if (pair && !(g == groups - 1 && $urandom_range(99) < 8)) begin
            send_byte({1'b0, data_value()});
            if (kind == KIND_NOTE_ON && chan == cur_chan)
               last_on_note = d0;
         end
      end
   endtask

   task automatic send_exclusive();
      int shape;
      int n_data;
      int spoil;
      logic [6:0] head [5];
      logic [6:0] value;
      shape = $urandom_range(99);
      value = ($urandom_range(9) < 8) ? 7'($urandom_range(1, 16)) : data_value();
      head[0] = maker_reg;
      head[1] = group_reg;
      head[2] = device_reg;
      head[3] = cmd_reg;
      head[4] = value;
      if (shape < 60) begin
         n_data = $urandom_range(5, 13);
      end else if (shape < 70) begin
         n_data = $urandom_range(5, 13);
         spoil = $urandom_range(3);
         head[3'(spoil)] = head[3'(spoil)] ^ 7'($urandom_range(1, 127));
      end else if (shape < 80) begin
         n_data = $urandom_range(0, 4);
      end else if (shape < 90) begin
         n_data = $urandom_range(14, 40);
      end else begin
         n_data = $urandom_range(5, 13);
      end
      send_byte(ST_SYSEX_START);
      for (int i = 0; i < n_data; i++)
         send_byte({1'b0, (i < 5) ? head[3'(i)] : data_value()});
      if (shape < 90)
         send_byte(ST_SYSEX_END);
      else
         send_byte(8'($urandom_range(8'h80, 8'hF6)));
      if (shape < 60 && value >= 7'd1 && value <= 7'd16)
         cur_chan = 4'(value - 7'd1);
   endtask

   task automatic send_random_traffic();
      int pick;
      pick = $urandom_range(99);
      if (pick < 65)
         send_voice_message();
      else if (pick < 80)
         send_exclusive();
      else if (pick < 88)
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      else if (pick < 94)
         send_byte(8'($urandom_range(8'hF1, 8'hF7)));
      else
         repeat ($urandom_range(1, 3)) send_byte({1'b0, data_value()});
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < OPENING_LEN; i++)
         send_byte(OPENING_BYTES[5'(i)]);
      cur_chan = 4'd15;
      last_on_note = 7'd60;
      for (int p = 0; p < 6; p++) begin
         int phase_goal;
         quiesce();
         case (p)
            0: set_registers(7'h00, 7'h00, 7'h00, 7'h00);
            1: set_registers(7'h7F, 7'h7F, 7'h7F, 7'h7F);
            4: set_registers(7'h7F, 7'h00, 7'h7F, 7'h00);
            default: set_registers(7'($urandom_range(127)), 7'($urandom_range(127)),
                                   7'($urandom_range(127)), 7'($urandom_range(127)));
         endcase
         send_idle_pct = (p < 2) ? 14 : (p < 4) ? 54 : 0;
         take_idle_pct = (p < 2) ? 54 : (p < 4) ? 14 : 0;
         hold_requests++;
         phase_goal = items_sent + PHASE_ITEMS;
         while (items_sent < phase_goal)
            send_random_traffic();
      end
      quiesce();
      $display("run covered %0d accepted bytes over six register settings and three pacing mixes",
               bytes_seen);
      $display("events checked: %0d note on, %0d release, %0d controller, %0d channel set",
               note_on_seen, release_seen, ctrl_seen, chan_set_seen);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
